// File: rtl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants
// Calibration entry layout, item action codes, pipeline stage enables and
// default parameter values for the lidar return calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package lrc_pkg;

    localparam int unsigned TABLE_DEPTH          = 64;
    localparam int unsigned LASER_W              = 6;
    localparam int unsigned LASERS_PER_BANK_DEF  = 32;
    localparam int unsigned STEPS_PER_TURN_DEF   = 36000;

    localparam logic [15:0] LOWER_BANK_CODE_RST  = 16'hDDFF;

    typedef enum logic [0:0] {
        ACT_RETURN = 1'b0,
        ACT_LOAD   = 1'b1
    } action_t;

    typedef struct packed {
        logic signed [15:0] rotation;
        logic signed [17:0] vertical;
        logic signed [31:0] square;
        logic signed [31:0] linear;
        logic signed [23:0] constant;
    } cal_entry_t;

    // per-stage advance enables, stage 2 through the output stage
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
        logic en5;
    } pipe_en_t;

endpackage

`default_nettype wire

// File: rtl/lidar_return_calibrator_core.sv
// ----------------------------------------------------------------------------
// lidar_return_calibrator_core: per-laser return calibration pipeline
// Applies rotational, vertical and quadratic range calibration to returns.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel (valid/ready) carries two kinds of items. A load transfer
//   (s_action = 1) writes one calibration entry at s_laser_index and gives
//   no result. A return transfer (s_action = 0) selects the lower bank when
//   s_header equals the lower bank code, else adds LASERS_PER_BANK to the
//   slot, reads that laser's entry and gives one m_* result: laser number,
//   wrapped heading, pitch, corrected and saturated range, pass-throughs.
//   cfg_wr_en/cfg_wr_data set the lower bank code; write only while idle.
// Timing:
//   Five register stages (table read, products, wide product, 66-bit sum,
//   saturate/output). One item per cycle sustained while m_ready is high;
//   a load followed directly by a return to the same laser sees the new
//   entry.
// Reset: aresetn (sync, active low) empties the pipeline and restores the
//   lower bank code to 0xDDFF. The table keeps its contents; an entry reads
//   as junk until loaded.
// Stall: each stage advances when it is empty or the next one advances, so
//   bubbles close up while m_ready is low and items hold without loss.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_return_calibrator_core
    import lrc_pkg::*;
#(
    parameter int unsigned LASERS_PER_BANK = LASERS_PER_BANK_DEF,
    parameter int unsigned STEPS_PER_TURN  = STEPS_PER_TURN_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_wr_en,
    input  wire logic [15:0]         cfg_wr_data,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_action,
    input  wire logic [15:0]         s_header,
    input  wire logic [5:0]          s_laser_index,
    input  wire logic [15:0]         s_rotation,
    input  wire logic [15:0]         s_range_raw,
    input  wire logic [7:0]          s_intensity,
    input  wire logic [15:0]         s_revolution,
    input  wire logic signed [15:0]  s_corr_rotation,
    input  wire logic signed [17:0]  s_corr_vertical,
    input  wire logic signed [31:0]  s_corr_square,
    input  wire logic signed [31:0]  s_corr_linear,
    input  wire logic signed [23:0]  s_corr_constant,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [5:0]               m_laser_id,
    output logic signed [15:0]       m_heading,
    output logic signed [17:0]       m_pitch,
    output logic signed [23:0]       m_range,
    output logic                     m_range_saturated,
    output logic [7:0]               m_intensity_out,
    output logic [15:0]              m_revolution_out
);

    localparam logic [LASER_W-1:0] UPPER_BANK_BASE = LASER_W'(LASERS_PER_BANK % TABLE_DEPTH);
    localparam logic [65:0] ROUND_HALF = 66'd1 << 31;
    localparam logic signed [34:0] RANGE_MAX = 35'sd8388607;
    localparam logic signed [34:0] RANGE_MIN = -35'sd8388608;

    // ---------------- configuration ----------------
    logic [15:0] lower_bank_code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_bank_code_reg <= LOWER_BANK_CODE_RST;
        end else if (cfg_wr_en) begin
            lower_bank_code_reg <= cfg_wr_data;
        end
    end

    // ---------------- stage control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1;
    pipe_en_t en;
    logic accept;
    logic is_load;

    always_comb begin
        en.en5  = !v5_reg || m_ready;
        en.en4  = !v4_reg || en.en5;
        en.en3  = !v3_reg || en.en4;
        en.en2  = !v2_reg || en.en3;
        en1     = !v1_reg || en.en2;
        accept  = s_valid && en1;
        is_load = (action_t'(s_action) == ACT_LOAD);
    end

    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            // loads retire at the table write and never enter the pipe
            if (en1)     v1_reg <= accept && !is_load;
            if (en.en2)  v2_reg <= v1_reg;
            if (en.en3)  v3_reg <= v2_reg;
            if (en.en4)  v4_reg <= v3_reg;
            if (en.en5)  v5_reg <= v4_reg;
        end
    end

    // ---------------- stage 1: bank select and table access ----------------
    logic [LASER_W-1:0] idx_next;
    cal_entry_t         load_entry;
    cal_entry_t         entry1;

    always_comb begin
        idx_next = s_laser_index +
                   ((s_header == lower_bank_code_reg) ? '0 : UPPER_BANK_BASE);
        load_entry.rotation = s_corr_rotation;
        load_entry.vertical = s_corr_vertical;
        load_entry.square   = s_corr_square;
        load_entry.linear   = s_corr_linear;
        load_entry.constant = s_corr_constant;
    end

    lrc_cal_table u_cal_table (
        .aclk    (aclk),
        .wr_en   (accept && is_load),
        .wr_addr (s_laser_index),
        .wr_data (load_entry),
        .rd_en   (en1),
        .rd_addr (idx_next),
        .rd_data (entry1)
    );

    logic [LASER_W-1:0] idx1_reg;
    logic [15:0]        rng1_reg;
    logic [15:0]        rot1_reg;
    logic [7:0]         int1_reg;
    logic [15:0]        rev1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            idx1_reg <= idx_next;
            rng1_reg <= s_range_raw;
            rot1_reg <= s_rotation;
            int1_reg <= s_intensity;
            rev1_reg <= s_revolution;
        end
    end

    // ---------------- heading ----------------
    lrc_heading #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_heading (
        .aclk          (aclk),
        .en            (en),
        .corr_rotation (entry1.rotation),
        .rotation      (rot1_reg),
        .heading       (m_heading)
    );

    // ---------------- stage 2: r*r and linear*r ----------------
    logic signed [16:0] r_s;
    logic [31:0]        rr_next;
    logic signed [48:0] lp_next;

    always_comb begin
        r_s     = $signed({1'b0, rng1_reg});
        rr_next = 32'(rng1_reg) * 32'(rng1_reg);
        lp_next = 49'(entry1.linear * r_s);
    end

    logic [31:0]        rr2_reg;
    logic signed [48:0] lp2_reg;
    logic signed [31:0] sq2_reg;
    logic signed [23:0] cst2_reg;
    logic signed [17:0] pit2_reg;
    logic [LASER_W-1:0] idx2_reg;
    logic [7:0]         int2_reg;
    logic [15:0]        rev2_reg;

    always_ff @(posedge aclk) begin
        if (en.en2) begin
            rr2_reg  <= rr_next;
            lp2_reg  <= lp_next;
            sq2_reg  <= entry1.square;
            cst2_reg <= entry1.constant;
            pit2_reg <= entry1.vertical;
            idx2_reg <= idx1_reg;
            int2_reg <= int1_reg;
            rev2_reg <= rev1_reg;
        end
    end

    // ---------------- stage 3: square * r^2 ----------------
    logic signed [32:0] rr_s;
    logic signed [64:0] p1_full;

    always_comb begin
        rr_s    = $signed({1'b0, rr2_reg});
        p1_full = 65'(sq2_reg * rr_s);
    end

    logic signed [63:0] p1_3_reg;
    logic signed [48:0] lp3_reg;
    logic signed [23:0] cst3_reg;
    logic signed [17:0] pit3_reg;
    logic [LASER_W-1:0] idx3_reg;
    logic [7:0]         int3_reg;
    logic [15:0]        rev3_reg;

    always_ff @(posedge aclk) begin
        if (en.en3) begin
            p1_3_reg <= p1_full[63:0];
            lp3_reg  <= lp2_reg;
            cst3_reg <= cst2_reg;
            pit3_reg <= pit2_reg;
            idx3_reg <= idx2_reg;
            int3_reg <= int2_reg;
            rev3_reg <= rev2_reg;
        end
    end

    // ---------------- stage 4: exact sum scaled by 2^32, round half up ----------------
    logic [65:0] sum_next;

    always_comb begin
        sum_next = {{2{p1_3_reg[63]}}, p1_3_reg}
                 + {lp3_reg[48], lp3_reg, 16'b0}
                 + ROUND_HALF;
    end

    logic [65:0]        sum4_reg;
    logic signed [23:0] cst4_reg;
    logic signed [17:0] pit4_reg;
    logic [LASER_W-1:0] idx4_reg;
    logic [7:0]         int4_reg;
    logic [15:0]        rev4_reg;

    always_ff @(posedge aclk) begin
        if (en.en4) begin
            sum4_reg <= sum_next;
            cst4_reg <= cst3_reg;
            pit4_reg <= pit3_reg;
            idx4_reg <= idx3_reg;
            int4_reg <= int3_reg;
            rev4_reg <= rev3_reg;
        end
    end

    // ---------------- stage 5: add constant, saturate, output ----------------
    logic signed [34:0] rng_wide;
    logic signed [23:0] rng_next;
    logic               sat_next;

    always_comb begin
        // floor of the scaled sum is its upper bits
        rng_wide = $signed({sum4_reg[65], sum4_reg[65:32]})
                 + $signed({{11{cst4_reg[23]}}, cst4_reg});
        if (rng_wide > RANGE_MAX) begin
            rng_next = RANGE_MAX[23:0];
            sat_next = 1'b1;
        end else if (rng_wide < RANGE_MIN) begin
            rng_next = RANGE_MIN[23:0];
            sat_next = 1'b1;
        end else begin
            rng_next = rng_wide[23:0];
            sat_next = 1'b0;
        end
    end

    logic [LASER_W-1:0] idx5_reg;
    logic signed [17:0] pit5_reg;
    logic signed [23:0] rng5_reg;
    logic               sat5_reg;
    logic [7:0]         int5_reg;
    logic [15:0]        rev5_reg;

    always_ff @(posedge aclk) begin
        if (en.en5) begin
            idx5_reg <= idx4_reg;
            pit5_reg <= pit4_reg;
            rng5_reg <= rng_next;
            sat5_reg <= sat_next;
            int5_reg <= int4_reg;
            rev5_reg <= rev4_reg;
        end
    end

    assign m_valid           = v5_reg;
    assign m_laser_id        = idx5_reg;
    assign m_pitch           = pit5_reg;
    assign m_range           = rng5_reg;
    assign m_range_saturated = sat5_reg;
    assign m_intensity_out   = int5_reg;
    assign m_revolution_out  = rev5_reg;

endmodule

`default_nettype wire

// File: rtl/lrc_cal_table.sv
// ----------------------------------------------------------------------------
// lrc_cal_table: per-laser calibration memory
// One entry per laser. Single write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_cal_table
    import lrc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [LASER_W-1:0]   wr_addr,
    input  wire cal_entry_t           wr_data,
    input  wire logic                 rd_en,
    input  wire logic [LASER_W-1:0]   rd_addr,
    output cal_entry_t                rd_data
);

    cal_entry_t mem [TABLE_DEPTH];
    cal_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/lrc_heading.sv
// ----------------------------------------------------------------------------
// lrc_heading: heading wrap pipeline
// Computes (correction - rotation) mod turn, centered on zero, over four
// stages: offset, reciprocal multiply, remainder, final correction.
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_heading
    import lrc_pkg::*;
#(
    parameter int unsigned STEPS_PER_TURN = STEPS_PER_TURN_DEF
) (
    input  wire logic               aclk,
    input  wire pipe_en_t           en,
    input  wire logic signed [15:0] corr_rotation,
    input  wire logic [15:0]        rotation,
    output logic signed [15:0]      heading
);

    // worst negative difference is -(2^16-1) - 2^15; lift by whole turns
    localparam int unsigned NEG_SPAN  = (2**16 - 1) + 2**15;
    localparam int unsigned OFF_TURNS = (NEG_SPAN + STEPS_PER_TURN - 1) / STEPS_PER_TURN;
    localparam int unsigned OFFSET    = OFF_TURNS * STEPS_PER_TURN;
    localparam int unsigned X_W       = 18;
    localparam int unsigned SH        = 34;
    localparam logic [SH-1:0]  RECIP  = SH'((64'd1 << SH) / STEPS_PER_TURN);
    localparam logic [X_W-1:0] TURN   = X_W'(STEPS_PER_TURN);
    localparam logic [X_W-1:0] HALF   = X_W'((STEPS_PER_TURN + 1) / 2);
    localparam logic signed [X_W:0] OFFSET_S = (X_W+1)'(OFFSET);

    logic [X_W-1:0]    x2_reg;
    logic [X_W-1:0]    x3_reg;
    logic [X_W-1:0]    q3_reg;
    logic [X_W-1:0]    rem4_reg;
    logic signed [15:0] heading_reg;

    logic signed [X_W:0] x2_next;
    logic [X_W+SH-1:0]   prod3_next;
    logic [X_W-1:0]      rem4_next;
    logic [X_W-1:0]      fold5;
    logic [X_W-1:0]      wrap5;

    always_comb begin
        x2_next    = (X_W+1)'(corr_rotation) - $signed({3'b000, rotation}) + OFFSET_S;
        prod3_next = (X_W+SH)'(x2_reg) * (X_W+SH)'(RECIP);
        rem4_next  = x3_reg - X_W'(q3_reg * TURN);
        // estimate may be one short: remainder lies in [0, 2*turn)
        fold5      = (rem4_reg >= TURN) ? rem4_reg - TURN : rem4_reg;
        wrap5      = (fold5 >= HALF) ? fold5 - TURN : fold5;
    end

    always_ff @(posedge aclk) begin
        if (en.en2) begin
            x2_reg <= X_W'(x2_next);
        end
        if (en.en3) begin
            x3_reg <= x2_reg;
            q3_reg <= prod3_next[SH +: X_W];
        end
        if (en.en4) begin
            rem4_reg <= rem4_next;
        end
        if (en.en5) begin
            heading_reg <= wrap5[15:0];
        end
    end

    assign heading = heading_reg;

endmodule

`default_nettype wire
